@@ rtl/core/tlpq_pkg.sv @@
// ----------------------------------------------------------------------------
// tlpq_pkg
// Types and codes shared by the three-level priority queue modules.
// ----------------------------------------------------------------------------
package tlpq_pkg;

   localparam int NUM_CLASSES = 3;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_TAKE   = 1'b1;

   localparam logic [1:0] CLS_URGENT = 2'd0;
   localparam logic [1:0] CLS_MIDDLE = 2'd1;
   localparam logic [1:0] CLS_LOW    = 2'd2;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_TAKEN    = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

@@ rtl/core/tlpq_store.sv @@
// ----------------------------------------------------------------------------
// tlpq_store
// Entry store holding the ring buffers of all three classes, with one write
// port and one registered read port.
// ----------------------------------------------------------------------------
module tlpq_store #(
   parameter int TAG_WIDTH = 16,
   parameter int ENTRIES   = 192,
   parameter int ADDR_W    = 8
) (
   input  logic                  clock,
   input  tlpq_pkg::mem_ctl_type mem_ctl,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [TAG_WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [TAG_WIDTH-1:0]  rd_data
);
   import tlpq_pkg::*;

   logic [TAG_WIDTH-1:0] mem [ENTRIES];
   logic [TAG_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/tlpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tlpq_ctrl
// Ring pointers and fill counts of the three classes, request decode,
// strict-priority selection and the response register.
// ----------------------------------------------------------------------------
module tlpq_ctrl #(
   parameter int CLASS_DEPTH = 64,
   parameter int ADDR_W      = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_type,
   input  logic [1:0]             req_priority,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tlpq_pkg::status_type   rsp_status,
   output logic [1:0]             rsp_priority,
   output tlpq_pkg::mem_ctl_type  mem_ctl,
   output logic [ADDR_W-1:0]      wr_addr,
   output logic [ADDR_W-1:0]      rd_addr
);
   import tlpq_pkg::*;

   localparam int PTR_W = $clog2(CLASS_DEPTH);
   localparam int CNT_W = $clog2(CLASS_DEPTH + 1);

   logic [PTR_W-1:0] rd_ptr_ff [NUM_CLASSES];
   logic [PTR_W-1:0] rd_ptr_in [NUM_CLASSES];
   logic [PTR_W-1:0] wr_ptr_ff [NUM_CLASSES];
   logic [PTR_W-1:0] wr_ptr_in [NUM_CLASSES];
   logic [CNT_W-1:0] count_ff  [NUM_CLASSES];
   logic [CNT_W-1:0] count_in  [NUM_CLASSES];

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   status_type       status_ff;
   status_type       status_in;
   logic [1:0]       prio_ff;
   logic [1:0]       prio_in;

   logic [NUM_CLASSES-1:0] full;
   logic [NUM_CLASSES-1:0] nonempty;
   logic [ADDR_W-1:0]      base [NUM_CLASSES];
   logic                   fire;
   logic                   ins_ok;
   logic                   take_ok;
   logic [1:0]             take_cls;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;

   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         full[c]     = (count_ff[c] == CNT_W'(CLASS_DEPTH));
         nonempty[c] = (count_ff[c] != '0);
         base[c]     = ADDR_W'(c * CLASS_DEPTH);
      end
   end

   always_comb begin
      unique case (req_priority)
         CLS_URGENT: ins_ok = !full[0];
         CLS_MIDDLE: ins_ok = !full[1];
         CLS_LOW:    ins_ok = !full[2];
         default:    ins_ok = 1'b0;
      endcase
   end

   always_comb begin
      take_ok  = 1'b1;
      take_cls = CLS_URGENT;
      if (nonempty[0]) begin
         take_cls = CLS_URGENT;
      end else if (nonempty[1]) begin
         take_cls = CLS_MIDDLE;
      end else if (nonempty[2]) begin
         take_cls = CLS_LOW;
      end else begin
         take_ok = 1'b0;
      end
   end

   always_comb begin
      wr_addr = '0;
      rd_addr = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (req_priority == 2'(c)) begin
            wr_addr = base[c] + ADDR_W'(wr_ptr_ff[c]);
         end
         if (take_cls == 2'(c)) begin
            rd_addr = base[c] + ADDR_W'(rd_ptr_ff[c]);
         end
      end
   end

   assign mem_ctl.wr_en = fire && (req_type == REQ_INSERT) && ins_ok;
   assign mem_ctl.rd_en = fire && (req_type == REQ_TAKE) && take_ok;

   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         rd_ptr_in[c] = rd_ptr_ff[c];
         wr_ptr_in[c] = wr_ptr_ff[c];
         count_in[c]  = count_ff[c];
         if (mem_ctl.wr_en && req_priority == 2'(c)) begin
            wr_ptr_in[c] = (wr_ptr_ff[c] == PTR_W'(CLASS_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff[c] + 1'b1;
            count_in[c]  = count_ff[c] + 1'b1;
         end
         if (mem_ctl.rd_en && take_cls == 2'(c)) begin
            rd_ptr_in[c] = (rd_ptr_ff[c] == PTR_W'(CLASS_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff[c] + 1'b1;
            count_in[c]  = count_ff[c] - 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      prio_in      = prio_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
         prio_in      = CLS_URGENT;
         if (req_type == REQ_INSERT) begin
            status_in = ins_ok ? ST_INSERTED : ST_FULL;
         end else if (take_ok) begin
            status_in = ST_TAKEN;
            prio_in   = take_cls;
         end else begin
            status_in = ST_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         status_ff    <= ST_INSERTED;
         prio_ff      <= CLS_URGENT;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            rd_ptr_ff[c] <= '0;
            wr_ptr_ff[c] <= '0;
            count_ff[c]  <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         prio_ff      <= prio_in;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            rd_ptr_ff[c] <= rd_ptr_in[c];
            wr_ptr_ff[c] <= wr_ptr_in[c];
            count_ff[c]  <= count_in[c];
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_priority = prio_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff[0] <= CNT_W'(CLASS_DEPTH) && count_ff[1] <= CNT_W'(CLASS_DEPTH)
      && count_ff[2] <= CNT_W'(CLASS_DEPTH))
      else $error("Class fill count exceeds the class depth.");

   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.wr_en && mem_ctl.rd_en))
      else $error("Store written and read by the same beat.");

   a_read_taken: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.rd_en |=> (rsp_valid_ff && status_ff == ST_TAKEN))
      else $error("Store read without a taken response.");

   a_empty_take: assert property (@(posedge clock) disable iff (reset)
      (fire && req_type == REQ_TAKE && nonempty == '0) |=> (status_ff == ST_EMPTY))
      else $error("Take on an empty queue not reported as empty.");

endmodule

@@ rtl/core/three_level_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// three_level_priority_queue_unit
// Strict-priority queue with urgent, middle and low classes, each a ring
// buffer in a shared entry store.
// ----------------------------------------------------------------------------
// Usage: a request beat on the req_ channel either inserts req_entry_tag into
// the class named by req_priority or takes the oldest entry of the highest
// non-empty class. Every request beat yields exactly one response beat on
// the rsp_ channel, carrying the status and, for a take, the tag and class.
// An insert into a full class, or with the unused class code, is refused
// with the full status; a take on an empty queue answers the empty status.
// The response is registered and follows in the cycle after acceptance. One
// request is accepted per cycle while no response is held; the entry store
// is used once per beat via its single write port and registered read port.
// The response is held in an output register: while rsp_ready is low a
// pending response stays and req_ready drops until it has been taken.
// Reset clears all pointers and fill counts, so every class starts empty;
// the entry store itself needs no clearing.
// ----------------------------------------------------------------------------
module three_level_priority_queue_unit #(
   parameter int CLASS_DEPTH = 64,
   parameter int TAG_WIDTH   = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   input  logic [1:0]           req_priority,
   input  logic [TAG_WIDTH-1:0] req_entry_tag,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [TAG_WIDTH-1:0] rsp_out_tag,
   output logic [1:0]           rsp_out_priority
);
   import tlpq_pkg::*;

   localparam int ENTRIES = NUM_CLASSES * CLASS_DEPTH;
   localparam int ADDR_W  = $clog2(ENTRIES);

   mem_ctl_type          mem_ctl;
   logic [ADDR_W-1:0]    wr_addr;
   logic [ADDR_W-1:0]    rd_addr;
   logic [TAG_WIDTH-1:0] rd_data;
   status_type           status;

   tlpq_ctrl #(
      .CLASS_DEPTH (CLASS_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_priority (req_priority),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (status),
      .rsp_priority (rsp_out_priority),
      .mem_ctl      (mem_ctl),
      .wr_addr      (wr_addr),
      .rd_addr      (rd_addr)
   );

   tlpq_store #(
      .TAG_WIDTH (TAG_WIDTH),
      .ENTRIES   (ENTRIES),
      .ADDR_W    (ADDR_W)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (req_entry_tag),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_status  = status;
   assign rsp_out_tag = (status == ST_TAKEN) ? rd_data : '0;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-level priority queue. A short table of
// requests covers the empty queue, the tag extremes, the unused class code
// and the priority order. Random segments follow that fill classes to
// overflow, drain them, mix the two and send refused requests. Every
// response beat is checked against a behavioural model of the three rings
// or a fixed answer of the table, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import tlpq_pkg::*;

   localparam int          CLASS_DEPTH = 64;
   localparam int          TAG_WIDTH   = 16;
   localparam logic [1:0]  CLS_UNUSED  = 2'd3;
   localparam int          ROW_COUNT   = 21;
   localparam int          TOTAL_ITEMS = 400;
   localparam int          QUIET_FROM  = 340;
   localparam int          STALL_LIMIT = 400;
   localparam int          DRAIN_WAIT  = 8;
   localparam logic        TYPED       = 1'b1;
   localparam logic        PREDICTED   = 1'b0;

   typedef struct packed {
      status_type     status;
      logic [15:0]    tag;
      logic [1:0]     cls;
   } queue_answer_type;

   typedef struct packed {
      logic              op;
      logic [1:0]        cls;
      logic [15:0]       tag;
      logic              typed;
      queue_answer_type  answer;
   } stim_row_type;

   typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIX, SEG_NOISE} segment_kind_type;

   localparam queue_answer_type NO_ANSWER = '{ST_INSERTED, 16'h0000, CLS_URGENT};

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic                 req_type         = REQ_INSERT;
   logic [1:0]           req_priority     = CLS_URGENT;
   logic [TAG_WIDTH-1:0] req_entry_tag    = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [1:0]           rsp_status;
   logic [TAG_WIDTH-1:0] rsp_out_tag;
   logic [1:0]           rsp_out_priority;

   logic [15:0]    class_ring [NUM_CLASSES][CLASS_DEPTH];
   int unsigned    ring_head  [NUM_CLASSES] = '{0, 0, 0};
   int unsigned    ring_tail  [NUM_CLASSES] = '{0, 0, 0};
   int unsigned    ring_fill  [NUM_CLASSES] = '{0, 0, 0};

   queue_answer_type  pending_answers [$];
   logic              row_typed   = PREDICTED;
   queue_answer_type  row_answer  = NO_ANSWER;
   logic              idling_on   = 1'b0;
   int unsigned       stall_left  = 0;
   int unsigned       items_sent  = 0;
   int unsigned       idle_cycles = 0;
   int unsigned       errors      = 0;
   stim_row_type      directed_rows [ROW_COUNT];

   three_level_priority_queue_unit #(
      .CLASS_DEPTH (CLASS_DEPTH),
      .TAG_WIDTH   (TAG_WIDTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_priority     (req_priority),
      .req_entry_tag    (req_entry_tag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_out_priority (rsp_out_priority)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic queue_answer_type serve_request(input logic op, input logic [1:0] cls,
                                                      input logic [15:0] tag);
      queue_answer_type ans;
      int c;
      bit found;
      ans = '{ST_EMPTY, 16'h0000, CLS_URGENT};
      found = 1'b0;
      if (op == REQ_INSERT) begin
         if (cls == CLS_UNUSED || ring_fill[cls] == CLASS_DEPTH) begin
            ans.status = ST_FULL;
         end else begin
            class_ring[cls][ring_head[cls]] = tag;
            ring_head[cls] = (ring_head[cls] + 1) % CLASS_DEPTH;
            ring_fill[cls]++;
            ans.status = ST_INSERTED;
         end
      end else begin
         for (c = 0; c < NUM_CLASSES; c++) begin
            if (!found && ring_fill[c] != 0) begin
               found = 1'b1;
               ans.status = ST_TAKEN;
               ans.tag = class_ring[c][ring_tail[c]];
               ans.cls = 2'(c);
               ring_tail[c] = (ring_tail[c] + 1) % CLASS_DEPTH;
               ring_fill[c]--;
            end
         end
      end
      return ans;
   endfunction

   // A receiver stall burst may start on any falling edge while idling is on.
   always @(negedge clock) begin
      if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 19);
      end
      if (stall_left > 0 && idling_on) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         stall_left = 0;
         rsp_ready  = 1'b1;
      end
   end

   always @(posedge clock) begin
      queue_answer_type want;
      queue_answer_type model;
      logic moved;
      moved = 1'b0;
      if (req_valid && req_ready) begin
         moved = 1'b1;
         model = serve_request(req_type, req_priority, req_entry_tag);
         pending_answers.push_back(row_typed ? row_answer : model);
      end
      if (rsp_valid === 1'b1 && rsp_ready) begin
         moved = 1'b1;
         if (pending_answers.size() == 0) begin
            errors++;
            $display("%0t: response beat with none expected, status %0d tag %h class %0d",
                     $realtime, rsp_status, rsp_out_tag, rsp_out_priority);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d, got %0d", $realtime, want.status,
                        rsp_status);
            end
            if (rsp_out_tag !== want.tag) begin
               errors++;
               $display("%0t: tag expected %h, got %h", $realtime, want.tag, rsp_out_tag);
            end
            if (rsp_out_priority !== want.cls) begin
               errors++;
               $display("%0t: class expected %0d, got %0d", $realtime, want.cls,
                        rsp_out_priority);
            end
         end
      end
      if (moved) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[three_level_priority_queue_unit] ERROR");
            $finish;
         end
      end
   end

   // Called on a falling edge; returns on the falling edge after the beat.
   task automatic send_request(input logic op, input logic [1:0] cls, input logic [15:0] tag,
                               input logic typed, input queue_answer_type fixed);
      if (items_sent >= QUIET_FROM) idling_on = 1'b0;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_type      = op;
      req_priority  = cls;
      req_entry_tag = tag;
      row_typed     = typed;
      row_answer    = fixed;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   initial begin
      int unsigned      i;
      int unsigned      seg;
      int unsigned      seg_len;
      logic [1:0]       cls_pick;
      segment_kind_type seg_kind;

      directed_rows = '{
         '{REQ_TAKE,   CLS_URGENT, 16'h0000, TYPED, '{ST_EMPTY,    16'h0000, CLS_URGENT}},
         '{REQ_TAKE,   CLS_UNUSED, 16'hFFFF, TYPED, '{ST_EMPTY,    16'h0000, CLS_URGENT}},
         '{REQ_INSERT, CLS_URGENT, 16'hFFFF, TYPED, '{ST_INSERTED, 16'h0000, CLS_URGENT}},
         '{REQ_INSERT, CLS_MIDDLE, 16'h0000, TYPED, '{ST_INSERTED, 16'h0000, CLS_URGENT}},
         '{REQ_INSERT, CLS_LOW,    16'h8001, PREDICTED, NO_ANSWER},
         '{REQ_INSERT, CLS_UNUSED, 16'h1234, TYPED, '{ST_FULL,     16'h0000, CLS_URGENT}},
         '{REQ_INSERT, CLS_LOW,    16'h7FFE, PREDICTED, NO_ANSWER},
         '{REQ_INSERT, CLS_MIDDLE, 16'hAAAA, PREDICTED, NO_ANSWER},
         '{REQ_INSERT, CLS_URGENT, 16'h5555, PREDICTED, NO_ANSWER},
         '{REQ_TAKE,   CLS_LOW,    16'h0000, TYPED, '{ST_TAKEN,    16'hFFFF, CLS_URGENT}},
         '{REQ_TAKE,   CLS_URGENT, 16'h0000, PREDICTED, NO_ANSWER},
         '{REQ_TAKE,   CLS_URGENT, 16'hFFFF, TYPED, '{ST_TAKEN,    16'h0000, CLS_MIDDLE}},
         '{REQ_INSERT, CLS_URGENT, 16'h0001, PREDICTED, NO_ANSWER},
         '{REQ_TAKE,   CLS_MIDDLE, 16'h0000, PREDICTED, NO_ANSWER},
         '{REQ_TAKE,   CLS_URGENT, 16'h0000, PREDICTED, NO_ANSWER},
         '{REQ_TAKE,   CLS_URGENT, 16'h0000, PREDICTED, NO_ANSWER},
         '{REQ_INSERT, CLS_MIDDLE, 16'hFFFE, PREDICTED, NO_ANSWER},
         '{REQ_TAKE,   CLS_LOW,    16'h3C3C, PREDICTED, NO_ANSWER},
         '{REQ_TAKE,   CLS_URGENT, 16'h0000, PREDICTED, NO_ANSWER},
         '{REQ_TAKE,   CLS_URGENT, 16'h0000, TYPED, '{ST_EMPTY,    16'h0000, CLS_URGENT}},
         '{REQ_INSERT, CLS_UNUSED, 16'h0000, TYPED, '{ST_FULL,     16'h0000, CLS_URGENT}}
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < ROW_COUNT; i++) begin
         send_request(directed_rows[i].op, directed_rows[i].cls, directed_rows[i].tag,
                      directed_rows[i].typed, directed_rows[i].answer);
      end

      // The first segment always fills one class beyond its depth, so that
      // refusals and pointer wrap are reached whatever the seed.
      seg = 0;
      while (items_sent < TOTAL_ITEMS) begin
         seg_kind  = (seg == 0) ? SEG_FILL : segment_kind_type'($urandom_range(0, 3));
         idling_on = ($urandom_range(0, 3) != 0);
         cls_pick  = 2'($urandom_range(0, 2));
         case (seg_kind)
            SEG_FILL: begin
               seg_len = $urandom_range(65, 72);
               for (i = 0; i < seg_len && items_sent < TOTAL_ITEMS; i++)
                  send_request(REQ_INSERT, cls_pick, 16'($urandom), PREDICTED, NO_ANSWER);
            end
            SEG_DRAIN: begin
               seg_len = $urandom_range(10, 80);
               for (i = 0; i < seg_len && items_sent < TOTAL_ITEMS; i++)
                  send_request(REQ_TAKE, 2'($urandom), 16'($urandom), PREDICTED, NO_ANSWER);
            end
            SEG_MIX: begin
               seg_len = $urandom_range(10, 40);
               for (i = 0; i < seg_len && items_sent < TOTAL_ITEMS; i++) begin
                  if ($urandom_range(0, 9) < 6)
                     send_request(REQ_INSERT, 2'($urandom_range(0, 2)), 16'($urandom),
                                  PREDICTED, NO_ANSWER);
                  else
                     send_request(REQ_TAKE, 2'($urandom), 16'($urandom), PREDICTED,
                                  NO_ANSWER);
               end
            end
            default: begin
               seg_len = $urandom_range(3, 10);
               for (i = 0; i < seg_len && items_sent < TOTAL_ITEMS; i++) begin
                  if ($urandom_range(0, 1) == 0)
                     send_request(REQ_INSERT, CLS_UNUSED, 16'($urandom), PREDICTED,
                                  NO_ANSWER);
                  else
                     send_request(REQ_TAKE, 2'($urandom), 16'($urandom), PREDICTED,
                                  NO_ANSWER);
               end
            end
         endcase
         seg++;
      end

      req_valid = 1'b0;
      idling_on = 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0 && pending_answers.size() == 0) begin
         $display("[three_level_priority_queue_unit] OK");
      end else begin
         $display("[three_level_priority_queue_unit] ERROR");
      end
      $finish;
   end

endmodule
